// ===== rtl/ternary_binary_matmul_macros.svh =====
// assertion macros shared by the checker of the ternary-binary matrix engine
// no dependencies; pulled in by include
`ifndef TERNARY_BINARY_MATMUL_MACROS_SVH
`define TERNARY_BINARY_MATMUL_MACROS_SVH

// property checked at every clock edge outside reset
`define TBM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tbm_pkg.sv =====
// shared types and constants of the ternary-binary matrix engine
// no dependencies; imported by every module of the block
package tbm_pkg;

  localparam int IN_W        = 32;
  localparam int LANE_EXT_W  = 64;
  localparam int CFG_W       = 13;
  localparam int DIM_W       = 13;
  localparam int IDX_W       = 12;
  localparam int SUM_W       = 14;
  localparam int POS_W       = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int LANES_DEF   = 32;
  localparam int MAX_DIM_DEF = 4096;
  localparam int MID_DEPTH   = 4;
  localparam int OUT_DEPTH   = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_LEN = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [IN_W-1:0] plus_bits;
    logic [IN_W-1:0] minus_bits;
    logic [IN_W-1:0] sign_bits;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] dot_sum;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic                    matrix_done;
  } res_t;

  // clamped output dimensions seen by the back end
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } dims_t;

endpackage

// ===== rtl/ternary_binary_matmul.sv =====
// Path: the chunk closing its inner length passes the front-end stage register, the
// middle queue and the result queue before its result is on the result ports. Throughput:
// one chunk per cycle while no queue is full; the front end counts lanes, the back accumulates.
// Reset: counters and accumulator cleared, rows_a 1, inner_len 8, cols_b 1, queues empty.
// top level: config registers, front end, middle queue, back end, result queue
// depends on tbm_pkg, tbm_fifo, tbm_front and tbm_back
module ternary_binary_matmul import tbm_pkg::*; #(
  parameter int LANES   = LANES_DEF,
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  in_t                  in_item_i,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output res_t                 res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int CW = $clog2(LANES + 1) + 1;
  localparam logic [DIM_W-1:0] DIM_CAP =
    (MAX_DIM > 2 ** DIM_W - 1) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIM);

  logic [CFG_W-1:0] rows_q, len_q, cols_q;
  logic [DIM_W-1:0] len_eff;
  dims_t            dims;
  logic             mid_push, mid_full, mid_pop, mid_empty;
  logic [CW:0]      mid_wdata, mid_rdata;
  logic             res_push, out_full;
  res_t             res_new;
  logic [$bits(res_t)-1:0] out_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(1);
      len_q  <= CFG_W'(8);
      cols_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS_A:    rows_q <= cfg_data_i;
        CFG_INNER_LEN: len_q  <= cfg_data_i;
        CFG_COLS_B:    cols_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // dimensions clamped to the supported maximum
  assign len_eff   = (len_q > DIM_CAP) ? DIM_CAP : len_q;
  assign dims.rows = (rows_q > DIM_CAP) ? DIM_CAP : rows_q;
  assign dims.cols = (cols_q > DIM_CAP) ? DIM_CAP : cols_q;

  tbm_front #(.LANES(LANES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (in_item_i),
    .full_o     (full),
    .len_i      (len_eff),
    .mid_push_o (mid_push),
    .mid_data_o (mid_wdata),
    .mid_full_i (mid_full)
  );

  tbm_fifo #(.WIDTH(CW + 1), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  tbm_back #(.LANES(LANES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_rdata),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  tbm_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_new),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign res_o = res_t'(out_rdata);

endmodule

// ===== rtl/tbm_fifo.sv =====
// small register queue used between front and back and on the result side
// depends on tbm_pkg only through the import convention
module tbm_fifo import tbm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = MID_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/tbm_front.sv =====
// front end: accepts chunks, masks lanes past the inner length, counts products
// depends on tbm_pkg; feeds the middle queue
module tbm_front import tbm_pkg::*; #(
  parameter int LANES = LANES_DEF,
  localparam int CW = $clog2(LANES + 1) + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  in_t              item_i,
  output logic             full_o,
  input  logic [DIM_W-1:0] len_i,
  output logic             mid_push_o,
  output logic [CW:0]      mid_data_o,
  input  logic             mid_full_i
);

  logic                    stage_v_q, stage_v_d;
  logic [LANES-1:0]        pos_vec_q, neg_vec_q, pos_vec_d, neg_vec_d;
  logic                    last_q, last_d;
  logic [POS_W-1:0]        pos_q, pos_d, pos_next;
  logic signed [POS_W:0]   remain;
  logic [LANE_EXT_W-1:0]   plus_ext, minus_ext, sign_ext;
  logic                    accept;
  logic signed [CW-1:0]    chunk;

  assign full_o     = stage_v_q && mid_full_i;
  assign accept     = push_i && !full_o;
  assign mid_push_o = stage_v_q && !mid_full_i;

  // lanes beyond the field width read as zero
  assign plus_ext  = LANE_EXT_W'(item_i.plus_bits);
  assign minus_ext = LANE_EXT_W'(item_i.minus_bits);
  assign sign_ext  = LANE_EXT_W'(item_i.sign_bits);

  // inner position and end of element
  assign pos_next = pos_q + POS_W'(LANES);
  assign last_d   = (pos_next >= POS_W'(len_i));
  assign remain   = $signed({2'b00, len_i}) - $signed({1'b0, pos_q});
  assign pos_d    = last_d ? '0 : pos_next;

  // per-lane product sign, lanes at or past the inner length masked
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      logic valid, nz, flip;
      valid = (remain > $signed((POS_W + 1)'(b)));
      nz    = plus_ext[b] ^ minus_ext[b];
      flip  = minus_ext[b] ^ sign_ext[b];
      pos_vec_d[b] = valid && nz && !flip;
      neg_vec_d[b] = valid && nz && flip;
    end
  end

  always_comb begin
    stage_v_d = stage_v_q;
    if (accept) begin
      stage_v_d = 1'b1;
    end else if (mid_push_o) begin
      stage_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
      pos_q     <= '0;
    end else begin
      stage_v_q <= stage_v_d;
      if (accept) begin
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_vec_q <= pos_vec_d;
      neg_vec_q <= neg_vec_d;
      last_q    <= last_d;
    end
  end

  // chunk sum as positive count minus negative count
  assign chunk      = CW'($countones(pos_vec_q)) - CW'($countones(neg_vec_q));
  assign mid_data_o = {last_q, chunk};

endmodule

// ===== rtl/tbm_back.sv =====
// back end: accumulates chunk sums, walks row and column counters, forms results
// depends on tbm_pkg; reads the middle queue and writes the result queue
module tbm_back import tbm_pkg::*; #(
  parameter int LANES = LANES_DEF,
  localparam int CW = $clog2(LANES + 1) + 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dims_t       dims_i,
  input  logic        mid_empty_i,
  input  logic [CW:0] mid_data_i,
  output logic        mid_pop_o,
  input  logic        out_full_i,
  output logic        res_push_o,
  output res_t        res_o
);

  localparam logic signed [SUM_W:0] SAT_HI = (SUM_W + 1)'(2 ** (SUM_W - 1) - 1);
  localparam logic signed [SUM_W:0] SAT_LO = -(SUM_W + 1)'(2 ** (SUM_W - 1));

  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic [DIM_W-1:0]        row_q, row_d, col_q, col_d;
  logic signed [CW-1:0]    chunk;
  logic                    last;
  logic signed [SUM_W:0]   sum, sat;
  logic                    last_col, last_row;

  assign chunk      = $signed(mid_data_i[CW-1:0]);
  assign last       = mid_data_i[CW];
  assign mid_pop_o  = !mid_empty_i && !out_full_i;
  assign res_push_o = mid_pop_o && last;

  // saturating accumulate
  assign sum = (SUM_W + 1)'(acc_q) + (SUM_W + 1)'(chunk);
  always_comb begin
    if (sum > SAT_HI) begin
      sat = SAT_HI;
    end else if (sum < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = sum;
    end
  end

  // row-major wrap of the output counters
  assign last_col = ({1'b0, col_q} + 1'b1) >= {1'b0, dims_i.cols};
  assign last_row = ({1'b0, row_q} + 1'b1) >= {1'b0, dims_i.rows};

  always_comb begin
    acc_d = acc_q;
    row_d = row_q;
    col_d = col_q;
    if (mid_pop_o) begin
      if (last) begin
        acc_d = '0;
        if (last_col) begin
          col_d = '0;
          row_d = last_row ? '0 : row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end else begin
        acc_d = sat[SUM_W-1:0];
      end
    end
  end

  assign res_o.dot_sum     = sat[SUM_W-1:0];
  assign res_o.out_row     = row_q[IDX_W-1:0];
  assign res_o.out_col     = col_q[IDX_W-1:0];
  assign res_o.matrix_done = last_col && last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      row_q <= '0;
      col_q <= '0;
    end else begin
      acc_q <= acc_d;
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ===== rtl/tbm_checker.sv =====
// port-level checks of the ternary-binary matrix engine, bound to the top level
// depends on tbm_pkg and ternary_binary_matmul_macros.svh
`include "ternary_binary_matmul_macros.svh"

module tbm_checker import tbm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input res_t res_o
);

  // a waiting result stays until taken
  `TBM_ASSERT_NEXT(a_res_kept, clk_i, rst_ni, !empty && !pop, !empty, "result dropped")

  // a waiting result does not change
  `TBM_ASSERT_NEXT(a_res_stable, clk_i, rst_ni, !empty && !pop, $stable(res_o), "result moved")

  // after the last result of a matrix the next one starts at the origin
  `TBM_ASSERT_NEXT(a_wrap_origin, clk_i, rst_ni, !empty && pop && res_o.matrix_done, empty || (res_o.out_row == '0 && res_o.out_col == '0), "no wrap after done")

  // queues come out of reset empty
  `TBM_ASSERT(a_reset_empty, clk_i, rst_ni, !$past(rst_ni) |-> (empty && !full), "not empty after reset")

endmodule

bind ternary_binary_matmul tbm_checker u_checker (.*);

// ===== test/tb_ternary_binary_matmul.sv =====
// self-checking testbench for the ternary-by-binary matrix product engine
// depends on tbm_pkg and the ternary_binary_matmul top level; predicts every result itself
module tb_ternary_binary_matmul;
  import tbm_pkg::*;

  localparam int LANES        = LANES_DEF;
  localparam int MAX_DIM      = MAX_DIM_DEF;
  localparam int ACC_HI       = 8191;
  localparam int ACC_LO       = -8192;
  localparam int DRAIN_CYCLES = 8;
  localparam int STUCK_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [IN_W-1:0] ONES = '1;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 push       = 1'b0;
  in_t                  in_item    = '0;
  logic                 full;
  logic                 empty;
  logic                 pop        = 1'b0;
  res_t                 res_o;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = CFG_ROWS_A;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  // idling and stall control
  int send_idle_pct = 31;
  int recv_idle_pct = 49;
  int hold_req      = 0;
  int hold_left     = 0;
  int stuck_cycles  = 0;
  int n_fail        = 0;

  // predicted engine state and registers
  logic [CFG_W-1:0] m_rows  = 13'd1;
  logic [CFG_W-1:0] m_inner = 13'd8;
  logic [CFG_W-1:0] m_cols  = 13'd1;
  int               m_acc   = 0;
  int               m_pos   = 0;
  int               m_row   = 0;
  int               m_col   = 0;
  res_t             pending_sums[$];

  ternary_binary_matmul u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic int clamp_dim(logic [CFG_W-1:0] v);
    return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  // fold one chunk into the predicted accumulator, queue a result when the inner length closes
  function automatic void advance_model(in_t c);
    int   len;
    int   rows;
    int   cols;
    int   part;
    logic last_c;
    logic last_r;
    res_t r;
    len  = clamp_dim(m_inner);
    rows = clamp_dim(m_rows);
    cols = clamp_dim(m_cols);
    part = 0;
    for (int b = 0; b < LANES; b++) begin
      if (m_pos + b >= len) break;
      if (c.plus_bits[b] != c.minus_bits[b]) begin
        part += (c.plus_bits[b] ^ c.sign_bits[b]) ? 1 : -1;
      end
    end
    m_acc += part;
    if (m_acc > ACC_HI) m_acc = ACC_HI;
    if (m_acc < ACC_LO) m_acc = ACC_LO;
    m_pos += LANES;
    if (m_pos < len) return;
    last_c        = (m_col + 1 >= cols);
    last_r        = (m_row + 1 >= rows);
    r.dot_sum     = m_acc[SUM_W-1:0];
    r.out_row     = m_row[IDX_W-1:0];
    r.out_col     = m_col[IDX_W-1:0];
    r.matrix_done = last_c && last_r;
    pending_sums.push_back(r);
    m_acc = 0;
    m_pos = 0;
    if (last_c) begin
      m_col = 0;
      m_row = last_r ? 0 : m_row + 1;
    end else begin
      m_col = m_col + 1;
    end
  endfunction

  task automatic report_bad(input string tag, input res_t want, input res_t got);
    n_fail++;
    if (n_fail <= 10) begin
      $display("%s: want sum %0d row %0d col %0d done %0b, got sum %0d row %0d col %0d done %0b",
               tag, $signed(want.dot_sum), want.out_row, want.out_col, want.matrix_done,
               $signed(got.dot_sum), got.out_row, got.out_col, got.matrix_done);
    end
  endtask

  // track register writes and accepted items, compare each popped result
  always @(posedge clk_i) begin : scoreboard
    res_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROWS_A:    m_rows  = cfg_data_i;
          CFG_INNER_LEN: m_inner = cfg_data_i;
          CFG_COLS_B:    m_cols  = cfg_data_i;
          default: ;
        endcase
      end
      if (push && !full) advance_model(in_item);
      if (pop && !empty) begin
        if (pending_sums.size() == 0) begin
          report_bad("unexpected result", '0, res_o);
        end else begin
          want = pending_sums.pop_front();
          if (res_o.dot_sum !== want.dot_sum || res_o.out_row !== want.out_row ||
              res_o.out_col !== want.out_col || res_o.matrix_done !== want.matrix_done) begin
            report_bad("result mismatch", want, res_o);
          end
        end
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (hold_req > 0) begin
      pop <= 1'b0;
      hold_left = hold_req - 1;
      hold_req  = 0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL ternary_binary_matmul");
      $finish;
    end
  end

  function automatic in_t chunk(logic [IN_W-1:0] p, logic [IN_W-1:0] m, logic [IN_W-1:0] s);
    in_t c;
    c.plus_bits  = p;
    c.minus_bits = m;
    c.sign_bits  = s;
    return c;
  endfunction

  function automatic logic [IN_W-1:0] rand_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return ONES;
      2:       return $urandom() & $urandom();
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim();
    case ($urandom_range(15))
      0:       return 13'd0;
      1:       return 13'd8191;
      2:       return CFG_W'($urandom_range(4097, 8191));
      3:       return CFG_W'($urandom_range(6, 40));
      default: return CFG_W'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_inner();
    case ($urandom_range(19))
      0:       return 13'd0;
      1:       return 13'd8191;
      2:       return CFG_W'(8 * $urandom_range(13, 512));
      3, 4:    return CFG_W'($urandom_range(1, 100));
      default: return CFG_W'(8 * $urandom_range(1, 12));
    endcase
  endfunction

  // offer one item, idling at random first; push stays high for a following item
  task automatic send_item(input in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // stop offering, wait for every predicted result, then let the pipeline settle
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                            input logic [CFG_W-1:0] cols);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ROWS_A;
    cfg_data_i <= rows;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INNER_LEN;
    cfg_data_i <= inner;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COLS_B;
    cfg_data_i <= cols;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // reset dimensions: one eight-element result per item, every ternary/binary pairing
  task automatic test_reset_defaults();
    send_item(chunk('0, '0, '0));
    send_item(chunk(ONES, '0, '0));
    send_item(chunk(ONES, '0, ONES));
    send_item(chunk('0, ONES, '0));
    send_item(chunk('0, ONES, ONES));
    send_item(chunk(ONES, ONES, $urandom()));
    send_item(chunk(32'hFFFF_FF00, 32'h0000_FF00, 32'h00FF_0000));
  endtask

  // inner length spanning two chunks, second chunk mostly masked
  task automatic test_lane_mask();
    drain_results();
    write_dims(13'd2, 13'd40, 13'd2);
    send_item(chunk(ONES, '0, '0));
    send_item(chunk(ONES, '0, '0));
    send_item(chunk('0, ONES, '0));
    send_item(chunk('0, ONES, '0));
    send_item(chunk(ONES, '0, ONES));
    send_item(chunk(32'hFFFF_FF00, '0, '0));
    send_item(chunk(32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F));
    send_item(chunk($urandom(), $urandom(), $urandom()));
  endtask

  // inner length off the multiple of eight, zero dimensions
  task automatic test_odd_dims();
    drain_results();
    write_dims(13'd0, 13'd12, 13'd0);
    send_item(chunk(ONES, '0, '0));
    send_item(chunk(32'h0000_0FFF, 32'h0000_0F00, 32'h0000_00F0));
    send_item(chunk($urandom(), $urandom(), $urandom()));
    drain_results();
    write_dims(13'd3, 13'd0, 13'd1);
    send_item(chunk(ONES, '0, '0));
    send_item(chunk('0, ONES, ONES));
    send_item(chunk($urandom(), $urandom(), $urandom()));
  endtask

  // oversized registers clamp to the largest size: full-scale positive and negative sums
  task automatic test_full_length();
    drain_results();
    write_dims(13'd8191, 13'd8191, 13'd3);
    repeat (128) send_item(chunk(ONES, '0, '0));
    repeat (128) send_item(chunk(ONES, '0, ONES));
  endtask

  // random segments, each with its own dimensions; counters carry across changes
  task automatic test_random(input int n_items, input int s_pct, input int r_pct);
    int sent;
    int seg;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      drain_results();
      write_dims(rand_dim(), rand_inner(), rand_dim());
      seg = $urandom_range(20, 80);
      repeat (seg) begin
        send_item(chunk(rand_word(), rand_word(), rand_word()));
        sent++;
      end
    end
  endtask

  // receiver holds off while items keep coming, so the input side backs up
  task automatic test_backpressure();
    drain_results();
    write_dims(13'd3, 13'd8, 13'd4);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = HOLD_CYCLES;
    repeat (48) send_item(chunk(rand_word(), rand_word(), rand_word()));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_lane_mask();
    test_odd_dims();
    test_full_length();
    test_random(320, 31, 49);
    test_random(320, 49, 31);
    test_random(320, 0, 0);
    test_backpressure();
    drain_results();
    if (n_fail == 0) begin
      $display("PASS ternary_binary_matmul");
    end else begin
      $display("FAIL ternary_binary_matmul");
    end
    $finish;
  end

endmodule
